>>> src/hce_pkg.sv
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types and constants of the hill cipher encrypt unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hce_pkg;

    localparam int LETTER_W  = 5;
    localparam int MAX_BLK   = 8;
    localparam int ROW_W     = MAX_BLK * LETTER_W;
    localparam int ROW_IDX_W = 3;
    localparam int SUM_W     = 13;
    localparam int PROD_W    = 25;
    localparam int QUOT_W    = 9;
    localparam int REM_W     = 6;

    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
    localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
    // floor(2^16 / 26), quotient estimate is exact or one low
    localparam logic [11:0]         RECIP_26   = 12'd2520;

    typedef logic [LETTER_W-1:0] t_letter;

    typedef struct packed {
        t_letter [MAX_BLK-1:0] blk;
        logic                  run_last;
        logic                  done;
        logic                  pad;
    } t_job;

endpackage

`default_nettype wire

>>> src/hce_front.sv
// ----------------------------------------------------------------------------
// hce_front
// Gathers letters into blocks and hands complete or padded blocks to the
// job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hce_front #(
    parameter int BLK    = 3,
    parameter int FILL_W = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire hce_pkg::t_letter      i_letter,
    input  wire logic                  i_end,
    input  wire logic                  i_full,
    output logic                       o_push,
    output hce_pkg::t_job              o_job
);
    import hce_pkg::*;

    t_letter [BLK-1:0]  r_blk;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic               w_xfer;
    logic               w_full_blk;

    assign o_ready    = !i_full;
    assign w_xfer     = i_valid && o_ready;
    assign w_full_blk = (r_fill == FILL_W'(BLK - 1));
    assign o_push     = w_xfer && (w_full_blk || i_end);

    always_comb begin
        for (int i = 0; i < MAX_BLK; i++) begin
            if (i >= BLK) begin
                o_job.blk[i] = PAD_LETTER;
            end else if (r_fill == FILL_W'(i)) begin
                o_job.blk[i] = i_letter;
            end else if (FILL_W'(i) > r_fill) begin
                o_job.blk[i] = PAD_LETTER;
            end else begin
                o_job.blk[i] = r_blk[i];
            end
        end
        o_job.run_last = w_full_blk ? !i_end : 1'b1;
        o_job.done     = !w_full_blk;
        o_job.pad      = w_full_blk && i_end;
    end

    always_comb begin
        n_fill = r_fill;
        if (w_xfer) begin
            if (w_full_blk || i_end) begin
                n_fill = '0;
            end else begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BLK; i++) begin
            if (w_xfer && r_fill == FILL_W'(i)) begin
                r_blk[i] <= i_letter;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/hce_fifo.sv
// ----------------------------------------------------------------------------
// hce_fifo
// Two-entry job queue between the block gatherer and the row engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hce_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hce_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output hce_pkg::t_job      o_job
);
    import hce_pkg::*;

    t_job        r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue underflow");

endmodule

`default_nettype wire

>>> src/hce_back.sv
// ----------------------------------------------------------------------------
// hce_back
// Row engine: one key row dot product per cycle while a job is queued and the
// output can advance, then mod 26 reduction into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hce_back #(
    parameter int BLK    = 3,
    parameter int FILL_W = 2
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [hce_pkg::ROW_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [hce_pkg::ROW_W-1:0]         i_cfg_data,
    input  wire logic                              i_empty,
    input  wire hce_pkg::t_job                     i_job,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output hce_pkg::t_letter                       o_letter,
    output logic                                   o_run_last,
    output logic                                   o_done
);
    import hce_pkg::*;

    logic [ROW_W-1:0]     r_key [MAX_BLK];
    logic [FILL_W-1:0]    r_row;
    logic                 r_pass;
    logic                 r_s1_vld;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_s1_rl;
    logic                 r_s1_dn;
    logic                 r_out_vld;
    t_letter              r_out_letter;
    logic                 r_out_rl;
    logic                 r_out_dn;

    logic                 w_out_free;
    logic                 w_issue;
    logic                 w_last_row;
    logic [ROW_W-1:0]     w_key_row;
    logic [SUM_W-1:0]     w_sum;
    logic [SUM_W-1:0]     w_k;
    logic [SUM_W-1:0]     w_l;
    logic [PROD_W-1:0]    w_prod;
    logic [QUOT_W-1:0]    w_quot;
    logic [REM_W-1:0]     w_rem;
    logic [REM_W-1:0]     w_rem_fix;

    assign w_out_free = !r_out_vld || i_ready;
    assign w_issue    = !i_empty && (!r_s1_vld || w_out_free);
    assign w_last_row = (r_row == FILL_W'(BLK - 1));
    assign o_pop      = w_issue && w_last_row && (r_pass || !i_job.pad);
    assign w_key_row  = r_key[ROW_IDX_W'(r_row)];

    // dot product of the selected key row with the block
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < BLK; k++) begin
            w_k   = SUM_W'(w_key_row[k*LETTER_W +: LETTER_W]);
            w_l   = SUM_W'(r_pass ? PAD_LETTER : i_job.blk[k]);
            w_sum = w_sum + SUM_W'(w_k * w_l);
        end
    end

    // mod 26 by reciprocal estimate and one correction
    always_comb begin
        w_prod    = PROD_W'(r_sum) * PROD_W'(RECIP_26);
        w_quot    = w_prod[PROD_W-1 -: QUOT_W];
        w_rem     = REM_W'(r_sum - SUM_W'(w_quot) * SUM_W'(MODULUS));
        w_rem_fix = (w_rem >= REM_W'(MODULUS)) ? (w_rem - REM_W'(MODULUS)) : w_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_BLK; r++) begin
                r_key[r] <= '0;
            end
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_pass    <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_issue) begin
                if (!w_last_row) begin
                    r_row <= r_row + FILL_W'(1);
                end else begin
                    r_row  <= '0;
                    r_pass <= !r_pass && i_job.pad;
                end
            end
            if (w_issue) begin
                r_s1_vld <= 1'b1;
            end else if (w_out_free) begin
                r_s1_vld <= 1'b0;
            end
            if (w_out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_sum   <= w_sum;
            r_s1_rl <= w_last_row && (r_pass || i_job.run_last);
            r_s1_dn <= w_last_row && (r_pass || i_job.done);
        end
        if (w_out_free && r_s1_vld) begin
            r_out_letter <= LETTER_W'(w_rem_fix);
            r_out_rl     <= r_s1_rl;
            r_out_dn     <= r_s1_dn;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_letter   = r_out_letter;
    assign o_run_last = r_out_rl;
    assign o_done     = r_out_dn;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done) |-> o_run_last)
        else $error("message end without run end");

    a_pad_pass_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass |-> !i_empty)
        else $error("padding pass without a job");

    a_cipher_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_letter < MODULUS))
        else $error("cipher letter out of range");

endmodule

`default_nettype wire

>>> src/hill_cipher_encrypt_unit.sv
// ----------------------------------------------------------------------------
// hill_cipher_encrypt_unit
// Hill cipher encryptor with streaming letter input and cipher letter output.
// ----------------------------------------------------------------------------
// One letter is taken per cycle while the two-entry job queue has room. Each
// completed block of KEY_SIZE letters yields KEY_SIZE cipher letters, one key
// row dot product per cycle while a job is queued and the output can advance,
// each held in the sum register and then the output register; a message whose
// length is a multiple of KEY_SIZE ends with a second pass of KEY_SIZE padding
// letters. Sustained, the row engine sets the pace at one cipher letter per
// cycle unless the output stalls, so about one letter per cycle on average.
// Key rows must be written only while the unit is idle; it is not enforced.
`default_nettype none

module hill_cipher_encrypt_unit #(
    parameter int KEY_SIZE = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [39:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // letter[4:0], zero fill
    input  wire logic        s_axis_tlast,   // message_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // cipher_letter[4:0], zero fill
    output logic             m_axis_tlast,   // run_last
    output logic             m_axis_tuser    // message_done
);
    import hce_pkg::*;

    localparam int BLK    = (KEY_SIZE < 1) ? 1 : ((KEY_SIZE > MAX_BLK) ? MAX_BLK : KEY_SIZE);
    localparam int FILL_W = (BLK < 2) ? 1 : $clog2(BLK);

    t_job     w_push_job;
    t_job     w_head_job;
    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    t_letter  w_cipher;

    hce_front #(
        .BLK    (BLK),
        .FILL_W (FILL_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_letter (s_axis_tdata[LETTER_W-1:0]),
        .i_end    (s_axis_tlast),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    hce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    hce_back #(
        .BLK    (BLK),
        .FILL_W (FILL_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_empty    (w_empty),
        .i_job      (w_head_job),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_letter   (w_cipher),
        .o_run_last (m_axis_tlast),
        .o_done     (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, w_cipher};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hill cipher encrypt unit: a directed table of
// letters under reset, saturated and textbook keys, then random messages under
// several key settings, each cipher letter checked against a block predictor or a known answer.
// ----------------------------------------------------------------------------
module tb_top;
    import hce_pkg::*;

    localparam int BLK            = 3;
    localparam int DRAIN_CYCLES   = 4 * BLK + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [2:0] {
        KEYS_RESET,
        KEYS_ZERO,
        KEYS_ONES,
        KEYS_CLASSIC,
        KEYS_RAW,
        KEYS_LETTERS
    } key_setting_e;

    typedef struct packed {
        t_letter cipher;
        logic    run_last;
        logic    msg_done;
    } cipher_result_t;

    typedef struct packed {
        key_setting_e keys;
        t_letter      ltr;
        logic         msg_end;
        logic         typed;
        t_letter      typed_val;
    } plain_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    logic [ROW_W-1:0]  i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // letter[4:0], zero fill
    logic              s_axis_tlast;   // message_end
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;   // cipher_letter[4:0], zero fill
    logic              m_axis_tlast;   // run_last
    logic              m_axis_tuser;   // message_done

    logic [ROW_W-1:0]  key_rows [MAX_BLK];
    t_letter [MAX_BLK-1:0] held_letters = '0;
    int                fill_level = 0;
    cipher_result_t    expected_ciphers [$];
    int                fail_count = 0;
    int                idle_cycles = 0;
    logic              row_typed = 1'b0;
    t_letter           row_typed_val = '0;
    logic              quiet = 1'b0;
    logic              src_gap_on = 1'b1;
    logic              sink_stall_on = 1'b1;

    // known answers: zero keys give zero, all-31 keys give 23 on 31s, 9 on
    // 31,31 padded, 22 on a lone 0 padded
    plain_row_t directed_rows [22] = '{
        '{KEYS_RESET,   5'd0,  1'b0, 1'b1, 5'd0},
        '{KEYS_RESET,   5'd25, 1'b0, 1'b1, 5'd0},
        '{KEYS_RESET,   5'd31, 1'b0, 1'b1, 5'd0},
        '{KEYS_RESET,   5'd7,  1'b1, 1'b1, 5'd0},
        '{KEYS_ONES,    5'd31, 1'b0, 1'b1, 5'd23},
        '{KEYS_ONES,    5'd31, 1'b0, 1'b1, 5'd23},
        '{KEYS_ONES,    5'd31, 1'b0, 1'b1, 5'd23},
        '{KEYS_ONES,    5'd31, 1'b0, 1'b1, 5'd9},
        '{KEYS_ONES,    5'd31, 1'b1, 1'b1, 5'd9},
        '{KEYS_ONES,    5'd0,  1'b1, 1'b1, 5'd22},
        '{KEYS_ONES,    5'd31, 1'b0, 1'b0, 5'd0},
        '{KEYS_ONES,    5'd31, 1'b0, 1'b0, 5'd0},
        '{KEYS_ONES,    5'd31, 1'b1, 1'b0, 5'd0},
        '{KEYS_CLASSIC, 5'd0,  1'b0, 1'b0, 5'd0},
        '{KEYS_CLASSIC, 5'd2,  1'b0, 1'b0, 5'd0},
        '{KEYS_CLASSIC, 5'd19, 1'b0, 1'b0, 5'd0},
        '{KEYS_CLASSIC, 5'd1,  1'b0, 1'b0, 5'd0},
        '{KEYS_CLASSIC, 5'd2,  1'b0, 1'b0, 5'd0},
        '{KEYS_CLASSIC, 5'd3,  1'b1, 1'b0, 5'd0},
        '{KEYS_CLASSIC, 5'd25, 1'b0, 1'b0, 5'd0},
        '{KEYS_CLASSIC, 5'd0,  1'b1, 1'b0, 5'd0},
        '{KEYS_CLASSIC, 5'd12, 1'b1, 1'b0, 5'd0}
    };

    key_setting_e random_plan [5] = '{KEYS_RAW, KEYS_ZERO, KEYS_LETTERS, KEYS_ONES,
                                      KEYS_LETTERS};
    int           random_items [5] = '{90, 30, 90, 60, 90};

    hill_cipher_encrypt_unit #(
        .KEY_SIZE(BLK)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_letter row_residue(int row, t_letter [MAX_BLK-1:0] blk);
        int acc;
        acc = 0;
        for (int k = 0; k < BLK; k++) begin
            acc += int'(key_rows[row][LETTER_W*k +: LETTER_W]) * int'(blk[k]);
        end
        return t_letter'(acc % int'(MODULUS));
    endfunction

    task automatic emit_block(t_letter [MAX_BLK-1:0] blk, logic closes_run,
                              logic closes_msg);
        cipher_result_t res;
        for (int j = 0; j < BLK; j++) begin
            res.cipher   = row_residue(j, blk);
            res.run_last = closes_run && (j == BLK - 1);
            res.msg_done = closes_msg && (j == BLK - 1);
            expected_ciphers.push_back(res);
        end
    endtask

    task automatic absorb_letter(t_letter ltr, logic msg_end);
        int pos;
        int first_new;
        t_letter [MAX_BLK-1:0] blk;
        pos = fill_level;
        if (pos >= BLK) pos = 0;
        first_new = expected_ciphers.size();
        held_letters[pos] = ltr;
        pos++;
        if (pos >= BLK) begin
            if (msg_end) begin
                emit_block(held_letters, 1'b0, 1'b0);
                blk = {MAX_BLK{PAD_LETTER}};
                emit_block(blk, 1'b1, 1'b1);
            end else begin
                emit_block(held_letters, 1'b1, 1'b0);
            end
            pos = 0;
        end else if (msg_end) begin
            blk = held_letters;
            for (int i = pos; i < MAX_BLK; i++) blk[i] = PAD_LETTER;
            emit_block(blk, 1'b1, 1'b1);
            pos = 0;
        end
        fill_level = pos;
        if (row_typed) begin
            for (int i = first_new; i < expected_ciphers.size(); i++) begin
                expected_ciphers[i].cipher = row_typed_val;
            end
        end
    endtask

    task automatic check_cipher();
        cipher_result_t exp_res;
        if (expected_ciphers.size() == 0) begin
            $display("%0t: unexpected cipher transfer, actual data %0d last %b user %b",
                     $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            fail_count++;
        end else begin
            exp_res = expected_ciphers.pop_front();
            if (m_axis_tdata !== {3'b000, exp_res.cipher}) begin
                $display("%0t: cipher letter mismatch, expected %0d actual %0d",
                         $time, exp_res.cipher, m_axis_tdata);
                fail_count++;
            end
            if (m_axis_tlast !== exp_res.run_last) begin
                $display("%0t: run_last mismatch, expected %b actual %b",
                         $time, exp_res.run_last, m_axis_tlast);
                fail_count++;
            end
            if (m_axis_tuser !== exp_res.msg_done) begin
                $display("%0t: message_done mismatch, expected %b actual %b",
                         $time, exp_res.msg_done, m_axis_tuser);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_letter(s_axis_tdata[LETTER_W-1:0], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_cipher();
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("hill_cipher_encrypt_unit test failed");
                $finish;
            end
        end
    end

    // output back-pressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0) sink_stall_on = ~sink_stall_on;
            if (!quiet && sink_stall_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_key_row(int row, logic [ROW_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= 3'(row);
        i_cfg_data <= val;
        key_rows[row] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_keys(key_setting_e setting);
        logic [ROW_W-1:0] val;
        if (setting != KEYS_RESET) begin
            for (int r = 0; r < MAX_BLK; r++) begin
                case (setting)
                    KEYS_ZERO: val = '0;
                    KEYS_ONES: val = '1;
                    KEYS_CLASSIC: begin
                        case (r)
                            0:       val = {25'd0, 5'd1,  5'd24, 5'd6};
                            1:       val = {25'd0, 5'd10, 5'd16, 5'd13};
                            2:       val = {25'd0, 5'd15, 5'd17, 5'd20};
                            default: val = ROW_W'({$urandom, $urandom});
                        endcase
                    end
                    KEYS_LETTERS: begin
                        for (int k = 0; k < MAX_BLK; k++) begin
                            val[LETTER_W*k +: LETTER_W] = t_letter'($urandom_range(0, 25));
                        end
                    end
                    default: val = ROW_W'({$urandom, $urandom});
                endcase
                write_key_row(r, val);
            end
        end
    endtask

    task automatic settle_unit(int extra);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_ciphers.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic send_letter(t_letter ltr, logic msg_end, logic typed, t_letter typed_val);
        @(negedge i_clk);
        if (!quiet && src_gap_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        row_typed     = typed;
        row_typed_val = typed_val;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ltr};
        s_axis_tlast  <= msg_end;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_letter rand_letter();
        if ($urandom_range(0, 7) == 0) return t_letter'($urandom_range(26, 31));
        return t_letter'($urandom_range(0, 25));
    endfunction

    initial begin
        key_setting_e cur_keys;
        int sent;
        int msg_len;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        for (int r = 0; r < MAX_BLK; r++) key_rows[r] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cur_keys = KEYS_RESET;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].keys != cur_keys) begin
                settle_unit(DRAIN_CYCLES);
                cur_keys = directed_rows[i].keys;
                load_keys(cur_keys);
            end
            src_gap_on = ($urandom_range(0, 1) == 0);
            send_letter(directed_rows[i].ltr, directed_rows[i].msg_end,
                        directed_rows[i].typed, directed_rows[i].typed_val);
        end

        foreach (random_plan[p]) begin
            settle_unit(DRAIN_CYCLES);
            load_keys(random_plan[p]);
            if (p == 4) quiet = 1'b1;
            sent = 0;
            while (sent < random_items[p]) begin
                msg_len = $urandom_range(1, 3 * BLK);
                if ($urandom_range(0, 3) == 0) msg_len = BLK * $urandom_range(1, 3);
                src_gap_on = ($urandom_range(0, 2) != 0);
                for (int i = 0; i < msg_len; i++) begin
                    send_letter(rand_letter(), i == msg_len - 1, 1'b0, '0);
                end
                sent += msg_len;
            end
        end

        settle_unit(DRAIN_CYCLES);
        if (fail_count == 0) begin
            $display("hill_cipher_encrypt_unit test passed");
        end else begin
            $display("hill_cipher_encrypt_unit test failed");
        end
        $finish;
    end

endmodule
